FILE: src/bmwa_pkg.sv
`timescale 1ns / 1ps

package bmwa_pkg;

  localparam int BUS_BITS        = 64;
  localparam int LINE_WORDS      = BUS_BITS / 32;
  localparam int STORE_WORDS_DEF = 65536;

  localparam int IN_DATA_W  = 112;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 2;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_AMO   = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_BADOP = 2'd2;

  localparam logic [3:0] AMO_ADD  = 4'd0;
  localparam logic [3:0] AMO_CLR  = 4'd1;
  localparam logic [3:0] AMO_SET  = 4'd2;
  localparam logic [3:0] AMO_XOR  = 4'd3;
  localparam logic [3:0] AMO_SMAX = 4'd4;
  localparam logic [3:0] AMO_SMIN = 4'd5;
  localparam logic [3:0] AMO_UMAX = 4'd6;
  localparam logic [3:0] AMO_UMIN = 4'd7;
  localparam logic [3:0] AMO_SWAP = 4'd8;
  localparam logic [3:0] AMO_LDEX = 4'd12;
  localparam logic [3:0] AMO_STEX = 4'd13;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [3:0] op;
    logic       dbl;
    logic       sel;
  } amo_ctl_t;

  typedef struct packed {
    logic [BUS_BITS-1:0] value;
    logic                ok;
  } amo_res_t;

endpackage

FILE: src/bus_memory_with_atomics_core.sv
`timescale 1ns / 1ps
// An accepted transaction is registered together with its line read, and its result is written
// to the output register in the execute step once it is free; only then is a new one accepted.
// A new transaction is accepted while the previous result still waits on the output side.
// Reset is synchronous; afterwards the valid-bit memory is cleared, all STORE_WORDS/2 lines in turn,
// during which no transaction is accepted, while configuration writes are still taken.
// After reset addr_limit is zero, so no address is out of range.

module bus_memory_with_atomics_core #(
  parameter int STORE_WORDS = bmwa_pkg::STORE_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [31:0]                       cfg_wdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // address[31:0], lane_mask[39:32], write_data[103:40], amo_op[107:104],
  // amo_double[108], zero padding above.
  input  logic [bmwa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // req_type[1:0].
  input  logic [bmwa_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // read_data[63:0].
  output logic [bmwa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status[1:0].
  output logic [bmwa_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

  localparam int LINES   = STORE_WORDS / bmwa_pkg::LINE_WORDS;
  localparam int LINE_AW = $clog2(LINES);

  bmwa_pkg::state_t state;
  bmwa_pkg::state_t state_next;

  logic [31:0]        addr_limit;
  logic [LINE_AW-1:0] clr_idx;
  logic               clr_we;
  logic               clr_last;
  logic               accept;
  logic               exec_fire;

  logic [1:0]  req_q;
  logic [31:0] addr_q;
  logic [7:0]  be_q;
  logic [63:0] wd_q;
  logic [3:0]  op_q;
  logic        dbl_q;

  logic [63:0] line_mem [LINES];
  logic [1:0]  valid_mem [LINES];
  logic [63:0] line_rd;
  logic [1:0]  valid_rd;

  logic [LINE_AW-1:0] rd_idx;
  logic [LINE_AW-1:0] wr_idx;
  logic               mem_we;
  logic [63:0]        new_line;
  logic [1:0]         new_valid;

  logic [31:0] st0;
  logic [31:0] st1;
  logic [31:0] w0;
  logic [31:0] w1;
  logic        oor0;
  logic        oor1;
  logic [3:0]  lanes0;
  logic [3:0]  lanes1;
  logic [63:0] rd_val;
  logic [1:0]  status_val;

  bmwa_pkg::amo_ctl_t amo_ctl;
  bmwa_pkg::amo_res_t amo_res;

  function automatic logic [31:0] merge_bytes(input logic [31:0] old_w,
                                              input logic [31:0] new_w,
                                              input logic [3:0]  lanes);
    logic [31:0] v;
    v = old_w;
    for (int b = 0; b < 4; b++) begin
      if (lanes[b]) begin
        v[8*b +: 8] = new_w[8*b +: 8];
      end
    end
    return v;
  endfunction

  always_comb begin
    state_next = state;
    unique case (state)
      bmwa_pkg::ST_CLEAR: if (clr_last) state_next = bmwa_pkg::ST_IDLE;
      bmwa_pkg::ST_IDLE:  if (s_axis_tvalid) state_next = bmwa_pkg::ST_EXEC;
      bmwa_pkg::ST_EXEC:  if (exec_fire) state_next = bmwa_pkg::ST_IDLE;
      default:            state_next = bmwa_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == bmwa_pkg::ST_IDLE);
    clr_we        = (state == bmwa_pkg::ST_CLEAR);
    exec_fire     = (state == bmwa_pkg::ST_EXEC) && (!m_axis_tvalid || m_axis_tready);
  end

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign clr_last = (clr_idx == LINE_AW'(LINES - 1));
  assign rd_idx   = s_axis_tdata[LINE_AW+2:3];
  assign wr_idx   = addr_q[LINE_AW+2:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bmwa_pkg::ST_CLEAR;
      clr_idx    <= '0;
      addr_limit <= '0;
    end else begin
      state <= state_next;
      if (clr_we) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cfg_we) begin
        addr_limit <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= s_axis_tuser[1:0];
      addr_q <= s_axis_tdata[31:0];
      be_q   <= s_axis_tdata[39:32];
      wd_q   <= s_axis_tdata[103:40];
      op_q   <= s_axis_tdata[107:104];
      dbl_q  <= s_axis_tdata[108];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= line_mem[rd_idx];
    end
    if (mem_we) begin
      line_mem[wr_idx] <= new_line;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      valid_rd <= valid_mem[rd_idx];
    end
    if (clr_we) begin
      valid_mem[clr_idx] <= '0;
    end else if (mem_we) begin
      valid_mem[wr_idx] <= new_valid;
    end
  end

  always_comb begin
    st0    = valid_rd[0] ? line_rd[31:0] : 32'd0;
    st1    = valid_rd[1] ? line_rd[63:32] : 32'd0;
    oor0   = (addr_limit != 32'd0) && ({addr_q[31:3], 3'b000} >= addr_limit);
    oor1   = (addr_limit != 32'd0) && ({addr_q[31:3], 3'b100} >= addr_limit);
    w0     = oor0 ? 32'd0 : st0;
    w1     = oor1 ? 32'd0 : st1;
    lanes0 = be_q[3:0];
    lanes1 = be_q[7:4];
    amo_ctl.op  = op_q;
    amo_ctl.dbl = dbl_q;
    amo_ctl.sel = addr_q[2];
  end

  bmwa_alu u_alu (
    .ctl      (amo_ctl),
    .old_line ({w1, w0}),
    .operand  (wd_q),
    .res      (amo_res)
  );

  always_comb begin
    new_line   = {st1, st0};
    new_valid  = valid_rd;
    rd_val     = '0;
    status_val = bmwa_pkg::STATUS_OK;
    mem_we     = 1'b0;
    unique case (req_q)
      bmwa_pkg::REQ_READ: begin
        rd_val = {w1, w0};
        if (oor0 || oor1) status_val = bmwa_pkg::STATUS_RANGE;
      end
      bmwa_pkg::REQ_WRITE: begin
        mem_we = exec_fire;
        if ((lanes0 != 4'd0 && oor0) || (lanes1 != 4'd0 && oor1)) begin
          status_val = bmwa_pkg::STATUS_RANGE;
        end
        if (lanes0 != 4'd0 && !oor0) begin
          new_line[31:0] = merge_bytes(st0, wd_q[31:0], lanes0);
          new_valid[0]   = 1'b1;
        end
        if (lanes1 != 4'd0 && !oor1) begin
          new_line[63:32] = merge_bytes(st1, wd_q[63:32], lanes1);
          new_valid[1]    = 1'b1;
        end
      end
      bmwa_pkg::REQ_AMO: begin
        rd_val = {w1, w0};
        if (oor0 || oor1) status_val = bmwa_pkg::STATUS_RANGE;
        if (!amo_res.ok) begin
          status_val = bmwa_pkg::STATUS_BADOP;
        end else begin
          mem_we = exec_fire;
          if (dbl_q) begin
            if (!oor0) begin
              new_line[31:0] = amo_res.value[31:0];
              new_valid[0]   = 1'b1;
            end
            if (!oor1) begin
              new_line[63:32] = amo_res.value[63:32];
              new_valid[1]    = 1'b1;
            end
          end else if (!addr_q[2]) begin
            if (!oor0) begin
              new_line[31:0] = amo_res.value[31:0];
              new_valid[0]   = 1'b1;
            end
          end else begin
            if (!oor1) begin
              new_line[63:32] = amo_res.value[31:0];
              new_valid[1]    = 1'b1;
            end
          end
        end
      end
      default: begin
        rd_val     = '0;
        status_val = bmwa_pkg::STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (exec_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      m_axis_tdata <= rd_val;
      m_axis_tuser <= status_val;
    end
  end

  a_write_only_in_exec: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == bmwa_pkg::ST_EXEC))
    else $error("line memory written outside the execute step");

  a_accept_leads_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == bmwa_pkg::ST_EXEC))
    else $error("accepted transaction did not enter the execute step");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    exec_fire |=> m_axis_tvalid)
    else $error("executed transaction produced no result");

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_we |-> !s_axis_tready)
    else $error("transaction accepted during the clearing pass");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("result carries an unused status code");

endmodule

FILE: src/bmwa_alu.sv
`timescale 1ns / 1ps

module bmwa_alu (
  input  bmwa_pkg::amo_ctl_t             ctl,
  input  logic [bmwa_pkg::BUS_BITS-1:0]  old_line,
  input  logic [bmwa_pkg::BUS_BITS-1:0]  operand,
  output bmwa_pkg::amo_res_t             res
);

  logic [63:0] mv;
  logic [63:0] cv;
  logic [31:0] mw;
  logic [31:0] cw;

  always_comb begin
    mw = ctl.sel ? old_line[63:32] : old_line[31:0];
    cw = ctl.sel ? operand[63:32] : operand[31:0];
    mv = ctl.dbl ? old_line : {{32{mw[31]}}, mw};
    cv = ctl.dbl ? operand : {{32{cw[31]}}, cw};
  end

  always_comb begin
    res.ok = 1'b1;
    unique case (ctl.op)
      bmwa_pkg::AMO_ADD:  res.value = mv + cv;
      bmwa_pkg::AMO_CLR:  res.value = mv & ~cv;
      bmwa_pkg::AMO_SET:  res.value = mv | cv;
      bmwa_pkg::AMO_XOR:  res.value = mv ^ cv;
      bmwa_pkg::AMO_SMAX: res.value = ($signed(mv) > $signed(cv)) ? mv : cv;
      bmwa_pkg::AMO_SMIN: res.value = ($signed(mv) < $signed(cv)) ? mv : cv;
      bmwa_pkg::AMO_UMAX: res.value = (mv > cv) ? mv : cv;
      bmwa_pkg::AMO_UMIN: res.value = (mv < cv) ? mv : cv;
      bmwa_pkg::AMO_SWAP: res.value = cv;
      bmwa_pkg::AMO_LDEX: res.value = mv;
      bmwa_pkg::AMO_STEX: res.value = cv;
      default: begin
        res.value = '0;
        res.ok    = 1'b0;
      end
    endcase
  end

endmodule
